[sv/fild_pkg.sv]
// Shared types and constants for the fall / impact latch detector.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fild_pkg;

    // Configuration port geometry: six 32-bit registers at byte offsets 4*i.
    localparam int unsigned CFG_AW = 5;
    localparam int unsigned CFG_DW = 32;

    // Register indexes (paddr[4:2]).
    localparam logic [2:0] REG_FALL_THR   = 3'd0;
    localparam logic [2:0] REG_MARGIN     = 3'd1;
    localparam logic [2:0] REG_IMPACT_EN  = 3'd2;
    localparam logic [2:0] REG_IMPACT_THR = 3'd3;
    localparam logic [2:0] REG_CONFIRM    = 3'd4;
    localparam logic [2:0] REG_STABLE     = 3'd5;

    // Register reset values.
    localparam logic [11:0] RST_FALL_THR   = 12'd720;
    localparam logic [11:0] RST_MARGIN     = 12'd160;
    localparam logic        RST_IMPACT_EN  = 1'b1;
    localparam logic [12:0] RST_IMPACT_THR = 13'd3000;
    localparam logic [15:0] RST_CONFIRM    = 16'd500;
    localparam logic [15:0] RST_STABLE     = 16'd2000;

    // Trigger codes stored with each log entry.
    localparam logic TRIG_IMPACT = 1'b0;
    localparam logic TRIG_TILT   = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [11:0] fall_thr;
        logic [11:0] margin;
        logic        impact_en;
        logic [12:0] impact_thr;
        logic [15:0] confirm;
        logic [15:0] stable;
    } t_cfg;

    typedef struct packed {
        logic [31:0] stamp;
        logic        trig;
        logic [11:0] angle;
    } t_entry;

    typedef struct packed {
        logic   wr;
        t_entry entry;
    } t_log_req;

endpackage

`default_nettype wire

[sv/fall_impact_latch_detector.sv]
// Top level of the fall / impact latch detector: handshake pipeline and result register.
// Depends on fild_pkg, fild_regs, fild_ctrl and fild_log.
//
// Usage. Each input word is a command: a sample (timestamp, tilt, acceleration), a clear
// of the fall latch, or a read of one log entry counted oldest first. Every accepted word
// gives exactly one result word with the latch state, the logged or read entry and the
// saturating total of falls logged. Both channels use valid and stall; a word moves at a
// rising edge at which valid is high and stall is low.
// A word accepted enters the input register, is decided as it moves into the result
// register (latch, timers, ring write or ring read) and its result is then offered there.
// Throughput is one word per clock unless the output stalls; the input register takes a new
// word while the result register still holds one that the receiver has not taken.
// When the receiver stalls, the result register holds its word and the input register
// fills; with both full the input stall is raised. The log read data comes from the ring
// memory's registered read port, which advances together with the result register.
// Reset (synchronous, active low) clears the latch, both timers, the write head, the event
// counter and both pipeline stages, and loads the configuration defaults. Log entries are
// not cleared; only entries that have been written can ever be read. The user must write
// configuration over the APB-style port while no word is in flight; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module fall_impact_latch_detector
    import fild_pkg::*;
#(
    parameter int unsigned LOG_DEPTH = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_command,
    input  wire logic [31:0]       i_now_ms,
    input  wire logic [11:0]       i_tilt_angle,
    input  wire logic [12:0]       i_accel_magnitude,
    input  wire logic [7:0]        i_log_index,
    // Output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_fallen,
    output logic                   o_event_logged,
    output logic                   o_entry_valid,
    output logic [31:0]            o_entry_time,
    output logic                   o_entry_trigger,
    output logic [11:0]            o_entry_angle,
    output logic [31:0]            o_event_total,
    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    // Input register stage.
    logic        r_s1_vld;
    logic [1:0]  r_s1_cmd;
    logic [31:0] r_s1_now;
    logic [11:0] r_s1_tilt;
    logic [12:0] r_s1_accel;
    logic [7:0]  r_s1_idx;

    // Result register stage.
    logic        r_s2_vld;
    logic        r_out_fallen;
    logic        r_out_logged;
    logic        r_out_valid;
    logic [31:0] r_out_time;
    logic        r_out_trig;
    logic [11:0] r_out_angle;
    logic [31:0] r_out_total;

    logic        n_s1_vld;
    logic        n_s2_vld;
    logic        s2_ready;
    logic        fire;
    logic        in_take;
    logic        out_take;
    logic        rd_cmd;

    t_cfg        cfg;
    t_cmd        s1_cmd;
    logic        fallen_next;
    t_log_req    log_req;
    logic        log_hit;
    t_entry      rd_entry;
    logic [31:0] count_next;

    // The result register frees when it is empty or its word is being taken; the input
    // register then hands its word on in the same edge.
    assign s2_ready   = !r_s2_vld || !i_out_stall;
    assign fire       = r_s1_vld && s2_ready;
    assign o_in_stall = r_s1_vld && !s2_ready;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_s2_vld && !i_out_stall;

    assign n_s1_vld = in_take ? 1'b1 : (fire ? 1'b0 : r_s1_vld);
    assign n_s2_vld = fire ? 1'b1 : (out_take ? 1'b0 : r_s2_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd   <= i_command;
            r_s1_now   <= i_now_ms;
            r_s1_tilt  <= i_tilt_angle;
            r_s1_accel <= i_accel_magnitude;
            r_s1_idx   <= i_log_index;
        end
    end

    assign s1_cmd = t_cmd'(r_s1_cmd);
    assign rd_cmd = (s1_cmd == CMD_READ);

    fild_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fild_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_cmd             (s1_cmd),
        .i_now_ms          (r_s1_now),
        .i_tilt_angle      (r_s1_tilt),
        .i_accel_magnitude (r_s1_accel),
        .i_cfg             (cfg),
        .o_fallen_next     (fallen_next),
        .o_log             (log_req)
    );

    fild_log #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_log (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_log        (log_req),
        .i_rd_en      (fire && rd_cmd),
        .i_log_index  (r_s1_idx),
        .o_hit        (log_hit),
        .o_rd_entry   (rd_entry),
        .o_count_next (count_next)
    );

    // Entry fields of a logging sample are captured here; those of a read come from the
    // ring memory's read register, selected after the register by the valid flag.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_fallen <= fallen_next;
            r_out_logged <= log_req.wr;
            r_out_valid  <= rd_cmd && log_hit;
            r_out_time   <= log_req.wr ? log_req.entry.stamp : '0;
            r_out_trig   <= log_req.wr ? log_req.entry.trig  : 1'b0;
            r_out_angle  <= log_req.wr ? log_req.entry.angle : '0;
            r_out_total  <= count_next;
        end
    end

    assign o_out_valid     = r_s2_vld;
    assign o_fallen        = r_out_fallen;
    assign o_event_logged  = r_out_logged;
    assign o_entry_valid   = r_out_valid;
    assign o_entry_time    = r_out_valid ? rd_entry.stamp : r_out_time;
    assign o_entry_trigger = r_out_valid ? rd_entry.trig  : r_out_trig;
    assign o_entry_angle   = r_out_valid ? rd_entry.angle : r_out_angle;
    assign o_event_total   = r_out_total;

    // A word that logs a fall must leave the latch set.
    a_logged_fallen : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_logged) |-> o_fallen)
        else $error("logged event without fall latch");

    // A result is either a log write or a log read, never both.
    a_log_or_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_event_logged && o_entry_valid))
        else $error("result both logged and read an entry");

    // A logged event is always counted.
    a_logged_counted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_logged) |-> (o_event_total != '0))
        else $error("logged event with zero total");

    // Input is only held off when the input register holds a word that cannot move on.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_vld && r_s2_vld && i_out_stall))
        else $error("input stalled without a blocked pipeline");

endmodule

`default_nettype wire

[sv/fild_regs.sv]
// Configuration register file on a simple APB-style slave port.
// Depends on fild_pkg for the register layout and reset values.
`timescale 1ns / 1ps
`default_nettype none

module fild_regs
    import fild_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_AW-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_FALL_THR:   n_cfg.fall_thr   = pwdata[11:0];
                REG_MARGIN:     n_cfg.margin     = pwdata[11:0];
                REG_IMPACT_EN:  n_cfg.impact_en  = pwdata[0];
                REG_IMPACT_THR: n_cfg.impact_thr = pwdata[12:0];
                REG_CONFIRM:    n_cfg.confirm    = pwdata[15:0];
                REG_STABLE:     n_cfg.stable     = pwdata[15:0];
                default:        n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fall_thr   <= RST_FALL_THR;
            r_cfg.margin     <= RST_MARGIN;
            r_cfg.impact_en  <= RST_IMPACT_EN;
            r_cfg.impact_thr <= RST_IMPACT_THR;
            r_cfg.confirm    <= RST_CONFIRM;
            r_cfg.stable     <= RST_STABLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FALL_THR:   prdata = CFG_DW'(r_cfg.fall_thr);
            REG_MARGIN:     prdata = CFG_DW'(r_cfg.margin);
            REG_IMPACT_EN:  prdata = CFG_DW'(r_cfg.impact_en);
            REG_IMPACT_THR: prdata = CFG_DW'(r_cfg.impact_thr);
            REG_CONFIRM:    prdata = CFG_DW'(r_cfg.confirm);
            REG_STABLE:     prdata = CFG_DW'(r_cfg.stable);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[sv/fild_ctrl.sv]
// Fall latch, tilt confirm timer and recovery timer.
// Depends on fild_pkg for the command codes, configuration and log request types.
`timescale 1ns / 1ps
`default_nettype none

module fild_ctrl
    import fild_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire t_cmd        i_cmd,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [11:0] i_tilt_angle,
    input  wire logic [12:0] i_accel_magnitude,
    input  wire t_cfg        i_cfg,
    output logic             o_fallen_next,
    output t_log_req         o_log
);

    logic        r_fall;
    logic        r_tilt_on;
    logic [31:0] r_tilt_start;
    logic        r_rec_on;
    logic [31:0] r_rec_start;
    logic        n_fall;
    logic        n_tilt_on;
    logic [31:0] n_tilt_start;
    logic        n_rec_on;
    logic [31:0] n_rec_start;

    logic        exceeds;
    logic        impact;
    logic [11:0] rec_thr;
    logic [31:0] tilt_elapsed;
    logic [31:0] rec_elapsed;
    logic        logged;
    logic        trig;

    assign exceeds = i_tilt_angle > i_cfg.fall_thr;
    assign impact  = i_cfg.impact_en && (i_accel_magnitude > i_cfg.impact_thr);
    assign rec_thr = (i_cfg.fall_thr > i_cfg.margin) ? (i_cfg.fall_thr - i_cfg.margin) : '0;

    // A timer that is not yet armed starts at this sample, so its elapsed time is zero.
    assign tilt_elapsed = r_tilt_on ? (i_now_ms - r_tilt_start) : '0;
    assign rec_elapsed  = r_rec_on  ? (i_now_ms - r_rec_start)  : '0;

    always_comb begin
        n_fall       = r_fall;
        n_tilt_on    = r_tilt_on;
        n_tilt_start = r_tilt_start;
        n_rec_on     = r_rec_on;
        n_rec_start  = r_rec_start;
        logged       = 1'b0;
        trig         = TRIG_IMPACT;
        case (i_cmd)
            CMD_SAMPLE: begin
                if (!r_fall) begin
                    if (impact) begin
                        n_fall   = 1'b1;
                        n_rec_on = 1'b0;
                        logged   = 1'b1;
                        trig     = TRIG_IMPACT;
                    end else if (exceeds) begin
                        n_tilt_on = 1'b1;
                        if (!r_tilt_on) begin
                            n_tilt_start = i_now_ms;
                        end
                        if (tilt_elapsed >= 32'(i_cfg.confirm)) begin
                            n_fall   = 1'b1;
                            n_rec_on = 1'b0;
                            logged   = 1'b1;
                            trig     = TRIG_TILT;
                        end
                    end else begin
                        n_tilt_on = 1'b0;
                    end
                end else begin
                    if ((i_tilt_angle < rec_thr) && !impact) begin
                        n_rec_on = 1'b1;
                        if (!r_rec_on) begin
                            n_rec_start = i_now_ms;
                        end
                        if (rec_elapsed >= 32'(i_cfg.stable)) begin
                            n_fall    = 1'b0;
                            n_rec_on  = 1'b0;
                            n_tilt_on = 1'b0;
                        end
                    end else begin
                        n_rec_on = 1'b0;
                    end
                end
            end
            CMD_CLEAR: begin
                n_fall    = 1'b0;
                n_rec_on  = 1'b0;
                n_tilt_on = 1'b0;
            end
            default: begin
                n_fall = r_fall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fall    <= 1'b0;
            r_tilt_on <= 1'b0;
            r_rec_on  <= 1'b0;
        end else if (i_fire) begin
            r_fall    <= n_fall;
            r_tilt_on <= n_tilt_on;
            r_rec_on  <= n_rec_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_tilt_start <= n_tilt_start;
            r_rec_start  <= n_rec_start;
        end
    end

    assign o_fallen_next     = n_fall;
    assign o_log.wr          = i_fire && logged;
    assign o_log.entry.stamp = i_now_ms;
    assign o_log.entry.trig  = trig;
    assign o_log.entry.angle = i_tilt_angle;

endmodule

`default_nettype wire

[sv/fild_log.sv]
// Event log: ring memory of LOG_DEPTH entries, write head and saturating event counter.
// Depends on fild_pkg for the entry and log request types.
`timescale 1ns / 1ps
`default_nettype none

module fild_log
    import fild_pkg::*;
#(
    parameter int unsigned LOG_DEPTH = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_log_req   i_log,
    input  wire logic       i_rd_en,
    input  wire logic [7:0] i_log_index,
    output logic            o_hit,
    output t_entry          o_rd_entry,
    output logic [31:0]     o_count_next
);

    localparam int unsigned AW = $clog2(LOG_DEPTH);
    localparam int unsigned CW = AW + 1;

    t_entry          mem [LOG_DEPTH];
    t_entry          r_rd_entry;
    logic [AW-1:0]   r_head;
    logic [AW-1:0]   n_head;
    logic [31:0]     r_count;
    logic [31:0]     n_count;

    logic            not_full;
    logic            wrapped;
    logic [CW-1:0]   avail;
    logic [AW-1:0]   start;
    logic [CW-1:0]   sum;
    logic [CW-1:0]   sum_fold;
    logic [AW-1:0]   rd_pos;

    // Number of stored entries and the oldest one's slot.
    assign not_full = r_count < 32'(LOG_DEPTH);
    assign wrapped  = r_count > 32'(LOG_DEPTH);
    assign avail    = not_full ? r_count[CW-1:0] : CW'(LOG_DEPTH);
    assign start    = wrapped ? r_head : '0;
    assign o_hit    = {1'b0, i_log_index} < 9'(avail);

    // Both terms are below the depth on a hit, so one subtraction folds the sum.
    assign sum      = {1'b0, start} + CW'(i_log_index[AW-1:0]);
    assign sum_fold = (sum >= CW'(LOG_DEPTH)) ? (sum - CW'(LOG_DEPTH)) : sum;
    assign rd_pos   = sum_fold[AW-1:0];

    assign n_head  = (r_head == AW'(LOG_DEPTH - 1)) ? '0 : (r_head + AW'(1));
    assign n_count = (i_log.wr && (r_count != '1)) ? (r_count + 32'd1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_log.wr) begin
                r_head <= n_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_log.wr) begin
            mem[r_head] <= i_log.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= mem[rd_pos];
        end
    end

    assign o_rd_entry   = r_rd_entry;
    assign o_count_next = n_count;

endmodule

`default_nettype wire
